FILE: rtl/mrl_pkg.sv
// Shared types and constants for the payload marker run-length parser.
`default_nettype none
package mrl_pkg;

	localparam logic [7:0]  MARKER_BYTE = 8'hFF;
	localparam logic [3:0]  MARKER_LEN  = 4'd8;
	localparam logic [3:0]  SEQ_LAST_POS = 4'd7;
	localparam logic [14:0] COUNT_MAX   = 15'h7FFF;
	localparam int          QUEUE_DEPTH = 4;
	localparam int          QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int          QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
	localparam logic [QUEUE_CW-1:0] QUEUE_ROOM_MAX = QUEUE_CW'(QUEUE_DEPTH - 2);

	typedef struct packed {
		logic signed [15:0] report_id;
		logic [31:0]        seq_number;
		logic [31:0]        thread_number;
		logic [14:0]        repeat_count;
		logic               last_report;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage
`default_nettype wire

FILE: rtl/mrl_parse.sv
// Input register, marker search and record run-length state.
`default_nettype none
module mrl_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [15:0] flow_id,
	input  logic [7:0]         payload_byte,
	input  logic               end_of_packet,
	input  logic               room,
	output mrl_pkg::push_t     push
);

	logic               valid_s1;
	logic signed [15:0] id_s1;
	logic [7:0]         byte_s1;
	logic               eop_s1;

	logic [3:0]  ff_q;
	logic        in_rec_q;
	logic [3:0]  pos_q;
	logic [63:0] shift_q;
	logic [31:0] seq_q;
	logic [31:0] thr_q;
	logic [14:0] cnt_q;

	logic [3:0]  ff_n;
	logic        in_rec_n;
	logic [3:0]  pos_n;
	logic [63:0] shift_n;
	logic [31:0] seq_n;
	logic [31:0] thr_n;
	logic [14:0] cnt_n;
	logic [3:0]  pos;
	logic        fire;
	logic        accept;
	logic        change_emit;
	logic        final_emit;
	mrl_pkg::result_t change_res;
	mrl_pkg::result_t final_res;

	assign fire       = valid_s1 & room;
	assign item_stall = valid_s1 & ~room;
	assign accept     = item_valid & ~item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			id_s1   <= flow_id;
			byte_s1 <= payload_byte;
			eop_s1  <= end_of_packet;
		end
	end

	always_comb begin
		ff_n        = ff_q;
		in_rec_n    = in_rec_q;
		pos         = pos_q;
		pos_n       = pos_q;
		shift_n     = shift_q;
		seq_n       = seq_q;
		thr_n       = thr_q;
		cnt_n       = cnt_q;
		change_emit = 1'b0;
		final_emit  = 1'b0;
		change_res  = '{id_s1, seq_q, thr_q, cnt_q, 1'b0};

		if (!in_rec_q) begin
			if (byte_s1 == mrl_pkg::MARKER_BYTE) begin
				if (ff_q < mrl_pkg::MARKER_LEN) begin
					ff_n = ff_q + 4'd1;
				end
			end else if (ff_q >= mrl_pkg::MARKER_LEN) begin
				in_rec_n = 1'b1;
				pos      = 4'd0;
			end else begin
				ff_n = 4'd0;
			end
		end

		if (in_rec_n) begin
			if (pos == 4'd0) begin
				shift_n = 64'd0;
			end
			if (!pos[3]) begin
				shift_n[{pos[2:0], 3'b000} +: 8] = byte_s1;
			end
			if (pos == mrl_pkg::SEQ_LAST_POS) begin
				if (shift_n[63:32] != seq_q || shift_n[31:0] != thr_q) begin
					change_emit = (cnt_q != 15'd0);
					cnt_n       = 15'd0;
				end
				seq_n = shift_n[63:32];
				thr_n = shift_n[31:0];
				if (cnt_n < mrl_pkg::COUNT_MAX) begin
					cnt_n = cnt_n + 15'd1;
				end
			end
			pos_n = pos + 4'd1;
		end

		final_res = '{id_s1, seq_n, thr_n, cnt_n, 1'b1};

		if (eop_s1) begin
			final_emit = in_rec_n | (ff_n >= mrl_pkg::MARKER_LEN);
			ff_n       = 4'd0;
			in_rec_n   = 1'b0;
			pos_n      = 4'd0;
			shift_n    = 64'd0;
			seq_n      = 32'd0;
			thr_n      = 32'd0;
			cnt_n      = 15'd0;
		end
	end

	always_comb begin
		push.count  = fire ? ({1'b0, change_emit} + {1'b0, final_emit}) : 2'd0;
		push.first  = change_emit ? change_res : final_res;
		push.second = final_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ff_q     <= 4'd0;
			in_rec_q <= 1'b0;
			pos_q    <= 4'd0;
			shift_q  <= 64'd0;
			seq_q    <= 32'd0;
			thr_q    <= 32'd0;
			cnt_q    <= 15'd0;
		end else if (fire) begin
			ff_q     <= ff_n;
			in_rec_q <= in_rec_n;
			pos_q    <= pos_n;
			shift_q  <= shift_n;
			seq_q    <= seq_n;
			thr_q    <= thr_n;
			cnt_q    <= cnt_n;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/mrl_queue.sv
// Report queue taking up to two reports per cycle and releasing one.
`default_nettype none
module mrl_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  mrl_pkg::push_t    push,
	output logic              room,
	output logic              report_valid,
	input  logic              report_stall,
	output mrl_pkg::result_t  head
);

	mrl_pkg::result_t mem_q [mrl_pkg::QUEUE_DEPTH];
	logic [mrl_pkg::QUEUE_AW-1:0] wr_q;
	logic [mrl_pkg::QUEUE_AW-1:0] rd_q;
	logic [mrl_pkg::QUEUE_CW-1:0] count_q;
	logic [mrl_pkg::QUEUE_AW-1:0] wr_next;
	logic                         pop;

	assign wr_next      = wr_q + mrl_pkg::QUEUE_AW'(1);
	assign report_valid = (count_q != '0);
	assign pop          = report_valid & ~report_stall;
	assign room         = (count_q <= mrl_pkg::QUEUE_ROOM_MAX);
	assign head         = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_next] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + mrl_pkg::QUEUE_AW'(push.count);
			count_q <= count_q + mrl_pkg::QUEUE_CW'(push.count)
				- mrl_pkg::QUEUE_CW'(pop);
			if (pop) begin
				rd_q <= rd_q + mrl_pkg::QUEUE_AW'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/payload_marker_run_length_parser_core.sv
// Top level of the payload marker run-length parser.
// Takes one payload byte per cycle while not stalled. A byte is registered and parsed from
// that register once the queue has room; its reports enter a four-entry queue. A byte that
// completes a record whose (sequence, thread) pair differs from a run already counted and
// also ends the packet yields two reports. The input stalls only while the report queue
// holds more than two reports, so a stalled report side backs up into the byte stream
// after a few reports. Reports carry the flow id of the byte that produced them.
`default_nettype none
module payload_marker_run_length_parser_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic signed [15:0] flow_id,
	input  logic [7:0]         payload_byte,
	input  logic               end_of_packet,
	output logic               report_valid,
	input  logic               report_stall,
	output logic signed [15:0] report_id,
	output logic [31:0]        seq_number,
	output logic [31:0]        thread_number,
	output logic [14:0]        repeat_count,
	output logic               last_report
);

	mrl_pkg::push_t   push;
	mrl_pkg::result_t head;
	logic             room;

	mrl_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.flow_id       (flow_id),
		.payload_byte  (payload_byte),
		.end_of_packet (end_of_packet),
		.room          (room),
		.push          (push)
	);

	mrl_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.head         (head)
	);

	assign report_id     = head.report_id;
	assign seq_number    = head.seq_number;
	assign thread_number = head.thread_number;
	assign repeat_count  = head.repeat_count;
	assign last_report   = head.last_report;

endmodule
`default_nettype wire

FILE: sim/mrl_report_checker.sv
// Report checker for the payload marker run-length parser: predicts and compares reports.
module mrl_report_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  logic signed [15:0] flow_id,
	input  logic [7:0]         payload_byte,
	input  logic               end_of_packet,
	input  logic               report_valid,
	input  logic               report_stall,
	input  logic signed [15:0] report_id,
	input  logic [31:0]        seq_number,
	input  logic [31:0]        thread_number,
	input  logic [14:0]        repeat_count,
	input  logic               last_report,
	output int                 mismatches,
	output int                 outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [3:0]       ff_seen;
	bit               in_records;
	logic [3:0]       rec_pos;
	logic [63:0]      rec_head;
	logic [31:0]      run_seq;
	logic [31:0]      run_thread;
	logic [14:0]      run_len;
	mrl_pkg::result_t expected_reports[$];
	int               fail_total;

	function automatic void clear_parser();
		ff_seen    = '0;
		in_records = 1'b0;
		rec_pos    = '0;
		rec_head   = '0;
		run_seq    = '0;
		run_thread = '0;
		run_len    = '0;
	endfunction

	function automatic void queue_report(logic signed [15:0] fid, logic last);
		expected_reports.push_back(
			mrl_pkg::result_t'{fid, run_seq, run_thread, run_len, last});
	endfunction

	function automatic void parse_byte(logic signed [15:0] fid, logic [7:0] b, logic eop);
		logic [31:0] thr;
		logic [31:0] seq;
		if (!in_records) begin
			if (b == mrl_pkg::MARKER_BYTE) begin
				if (ff_seen < mrl_pkg::MARKER_LEN)
					ff_seen++;
			end else if (ff_seen >= mrl_pkg::MARKER_LEN) begin
				in_records = 1'b1;
				rec_pos    = '0;
			end else begin
				ff_seen = '0;
			end
		end
		if (in_records) begin
			if (rec_pos == 4'd0)
				rec_head = '0;
			if (rec_pos < 4'd8)
				rec_head[8*rec_pos +: 8] = b;
			if (rec_pos == mrl_pkg::SEQ_LAST_POS) begin
				thr = rec_head[31:0];
				seq = rec_head[63:32];
				if (seq != run_seq || thr != run_thread) begin
					if (run_len != '0)
						queue_report(fid, 1'b0);
					run_len = '0;
				end
				run_seq    = seq;
				run_thread = thr;
				if (run_len < mrl_pkg::COUNT_MAX)
					run_len++;
			end
			rec_pos = rec_pos + 4'd1;
		end
		if (eop) begin
			if (in_records || ff_seen >= mrl_pkg::MARKER_LEN)
				queue_report(fid, 1'b1);
			clear_parser();
		end
	endfunction

	function automatic void check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
		if (got_v !== want_v) begin
			$error("%s expected 0x%0h, got 0x%0h", name, want_v, got_v);
			fail_total++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		mrl_pkg::result_t want;
		if (!arst_n) begin
			clear_parser();
			expected_reports.delete();
			fail_total = 0;
		end else begin
			if (report_valid && !report_stall) begin
				if (expected_reports.size() == 0) begin
					$error("unexpected report: id %0d seq 0x%0h thread 0x%0h count %0d last %0b",
						report_id, seq_number, thread_number, repeat_count, last_report);
					fail_total++;
				end else begin
					want = expected_reports.pop_front();
					check_field("report_id", want.report_id, report_id);
					check_field("seq_number", want.seq_number, seq_number);
					check_field("thread_number", want.thread_number, thread_number);
					check_field("repeat_count", want.repeat_count, repeat_count);
					check_field("last_report", want.last_report, last_report);
				end
			end
			if (item_valid && !item_stall)
				parse_byte(flow_id, payload_byte, end_of_packet);
		end
		mismatches  <= fail_total;
		outstanding <= expected_reports.size();
	end

endmodule

FILE: sim/tb.sv
// Testbench top for the payload marker run-length parser: stimulus, idling, report stalls and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic [7:0] octets_t[$];

	localparam int PHASE_BYTES = 425;
	localparam int DRAIN_CYCLES = 20;
	localparam int STALL_LIMIT = 4000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic signed [15:0] flow_id = '0;
	logic [7:0]         payload_byte = '0;
	logic               end_of_packet = 1'b0;
	logic               report_valid;
	logic               report_stall = 1'b0;
	logic signed [15:0] report_id;
	logic [31:0]        seq_number;
	logic [31:0]        thread_number;
	logic [14:0]        repeat_count;
	logic               last_report;
	int                 mismatches;
	int                 outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	int quiet_cycles = 0;
	int phase_idle[4] = '{0, 72, 0, 37};
	int phase_stall[4] = '{0, 0, 72, 37};

	payload_marker_run_length_parser_core DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.flow_id      (flow_id),
		.payload_byte (payload_byte),
		.end_of_packet(end_of_packet),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_id    (report_id),
		.seq_number   (seq_number),
		.thread_number(thread_number),
		.repeat_count (repeat_count),
		.last_report  (last_report)
	);

	mrl_report_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.flow_id      (flow_id),
		.payload_byte (payload_byte),
		.end_of_packet(end_of_packet),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report_id    (report_id),
		.seq_number   (seq_number),
		.thread_number(thread_number),
		.repeat_count (repeat_count),
		.last_report  (last_report),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		report_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (report_valid && !report_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb failed");
				$finish;
			end
		end
	end

	task automatic put_byte(input logic signed [15:0] fid, input logic [7:0] b, input logic eop);
		while ($urandom_range(0, 99) < idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid    <= 1'b1;
		flow_id       <= fid;
		payload_byte  <= b;
		end_of_packet <= eop;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
	endtask

	task automatic send_packet(input octets_t pkt, input bit fixed_id,
		input logic signed [15:0] fid);
		for (int i = 0; i < pkt.size(); i++)
			put_byte(fixed_id ? fid : 16'($urandom), pkt[i], i == pkt.size() - 1);
	endtask

	function automatic void add_record(ref octets_t pkt, input logic [31:0] seq,
		input logic [31:0] thr);
		for (int i = 0; i < 4; i++)
			pkt.push_back(thr[8*i +: 8]);
		for (int i = 0; i < 4; i++)
			pkt.push_back(seq[8*i +: 8]);
		for (int i = 0; i < 8; i++)
			pkt.push_back(8'($urandom));
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_directed_packets();
		octets_t pkt;
		// lone byte, no marker
		pkt = '{8'h00};
		send_packet(pkt, 1'b1, 16'sh0000);
		// marker ends on the last byte of the packet
		pkt = {};
		repeat (8) pkt.push_back(mrl_pkg::MARKER_BYTE);
		send_packet(pkt, 1'b1, 16'sh7FFF);
		// one FF short of a marker
		pkt = {};
		repeat (7) pkt.push_back(mrl_pkg::MARKER_BYTE);
		pkt.push_back(8'h00);
		send_packet(pkt, 1'b1, -16'sd32768);
		// a split FF run must not join across packets
		pkt = {};
		repeat (5) pkt.push_back(mrl_pkg::MARKER_BYTE);
		send_packet(pkt, 1'b1, 16'sh1234);
		pkt = {};
		repeat (3) pkt.push_back(mrl_pkg::MARKER_BYTE);
		pkt.push_back(8'h10);
		send_packet(pkt, 1'b1, 16'sh1234);
		// marker found, packet ends on the first record byte
		pkt = {};
		repeat (8) pkt.push_back(mrl_pkg::MARKER_BYTE);
		pkt.push_back(8'h01);
		send_packet(pkt, 1'b1, -16'sd1);
		// long FF run, leading zero pairs, pair change on the final byte
		pkt = {};
		repeat (12) pkt.push_back(mrl_pkg::MARKER_BYTE);
		add_record(pkt, 32'h0, 32'h0);
		add_record(pkt, 32'h0, 32'h0);
		add_record(pkt, 32'hA5A5_0F0F, 32'h8000_0001);
		repeat (8) void'(pkt.pop_back());
		send_packet(pkt, 1'b0, 16'sh0);
	endtask

	task automatic build_random_packet(output octets_t pkt);
		logic [31:0] pool_seq[3];
		logic [31:0] pool_thr[3];
		int          kind;
		int          pick;
		int          cut;
		pkt  = {};
		kind = $urandom_range(0, 99);
		if (kind < 75) begin
			for (int k = 0; k < 3; k++) begin
				pool_seq[k] = pick_word();
				pool_thr[k] = pick_word();
				if (pool_thr[k][7:0] == mrl_pkg::MARKER_BYTE)
					pool_thr[k][7:0] = 8'hFE;
			end
			repeat ($urandom_range(0, 5)) pkt.push_back(8'($urandom_range(0, 254)));
			repeat ($urandom_range(8, 11)) pkt.push_back(mrl_pkg::MARKER_BYTE);
			pick = $urandom_range(0, 2);
			repeat ($urandom_range(0, 6)) begin
				if ($urandom_range(0, 99) < 40)
					pick = $urandom_range(0, 2);
				add_record(pkt, pool_seq[pick], pool_thr[pick]);
			end
			if ($urandom_range(0, 1)) begin
				if ($urandom_range(0, 99) < 60)
					pick = $urandom_range(0, 2);
				add_record(pkt, pool_seq[pick], pool_thr[pick]);
				cut = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, 15);
				repeat (16 - cut) void'(pkt.pop_back());
			end
		end else if (kind < 90) begin
			repeat ($urandom_range(1, 40))
				pkt.push_back($urandom_range(0, 1) ? mrl_pkg::MARKER_BYTE : 8'($urandom));
		end else begin
			repeat ($urandom_range(1, 7)) pkt.push_back(mrl_pkg::MARKER_BYTE);
			repeat ($urandom_range(0, 20)) pkt.push_back(8'($urandom_range(0, 254)));
		end
	endtask

	initial begin
		octets_t pkt;
		int      sent;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			if (ph == 0)
				run_directed_packets();
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_random_packet(pkt);
				send_packet(pkt, $urandom_range(0, 3) == 0, 16'($urandom));
				sent += pkt.size();
			end
		end
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
